// ----- rtl/uts_pkg.sv -----
// Shared types, constants and character tables of the UTF-8 source tokenizer.
`default_nettype none

package uts_pkg;

    localparam int DEF_OFFSET_BITS   = 24;
    localparam int DEF_POSITION_BITS = 20;

    localparam int OFS_W = 24;
    localparam int POS_W = 20;
    localparam int CP_W  = 21;

    localparam logic [5:0] K_ERR    = 6'd44;
    localparam logic [5:0] K_STRING = 6'd59;
    localparam logic [5:0] K_IDENT  = 6'd60;
    localparam logic [5:0] K_INT    = 6'd61;
    localparam logic [5:0] K_FLOAT  = 6'd62;
    localparam logic [5:0] K_EOF    = 6'd63;

    // Operator trie transitions: with GO_KIND set the low bits are a token kind.
    localparam logic [6:0] GO_KIND = 7'h40;
    localparam logic [6:0] GO_NONE = 7'h00;
    localparam logic [7:0] CH_NONE = 8'h00;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } src_word_t;

    typedef struct packed {
        logic [5:0]       token_kind;
        logic [OFS_W-1:0] start_offset;
        logic [OFS_W-1:0] lexeme_length;
        logic [POS_W-1:0] line_number;
        logic [POS_W-1:0] column_number;
        logic [1:0]       number_radix;
        logic             last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0]       count;
        token_t [2:0]     item;
    } tok_group_t;

    typedef struct packed {
        logic [5:0]       dflt;
        logic [3:0][7:0]  ch;
        logic [3:0][6:0]  go;
    } op_node_t;

    function automatic op_node_t mk(input logic [5:0] d,
                                    input logic [7:0] c0, input logic [6:0] g0,
                                    input logic [7:0] c1, input logic [6:0] g1,
                                    input logic [7:0] c2, input logic [6:0] g2,
                                    input logic [7:0] c3, input logic [6:0] g3);
        op_node_t n;
        n.dflt = d;
        n.ch   = {c3, c2, c1, c0};
        n.go   = {g3, g2, g1, g0};
        return n;
    endfunction

    function automatic op_node_t op_node(input logic [4:0] idx);
        op_node_t n;
        case (idx)
            5'd1:  n = mk(6'd16, "=", GO_KIND | 7'd14, "+", GO_KIND | 7'd15,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd2:  n = mk(6'd20, ">", GO_KIND | 7'd17, "=", GO_KIND | 7'd18,
                          "-", GO_KIND | 7'd19, CH_NONE, GO_NONE);
            5'd3:  n = mk(6'd24, "*", 7'd14, "=", GO_KIND | 7'd23,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd4:  n = mk(6'd22, "=", GO_KIND | 7'd21, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd5:  n = mk(6'd26, "=", GO_KIND | 7'd25, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd6:  n = mk(6'd28, "=", GO_KIND | 7'd27, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd7:  n = mk(6'd29, "&", GO_KIND | 7'd29, "=", GO_KIND | 7'd30,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd8:  n = mk(6'd31, "|", GO_KIND | 7'd31, "=", GO_KIND | 7'd32,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd9:  n = mk(6'd34, "=", GO_KIND | 7'd33, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd10: n = mk(6'd44, "=", GO_KIND | 7'd35, "+", 7'd21,
                          "-", 7'd22, "*", 7'd23);
            5'd11: n = mk(6'd37, "=", GO_KIND | 7'd36, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd12: n = mk(6'd39, "=", GO_KIND | 7'd38, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd13: n = mk(6'd43, "*", 7'd24, "=", GO_KIND | 7'd42,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd14: n = mk(6'd41, "=", GO_KIND | 7'd40, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd15: n = mk(6'd50, "<", 7'd26, "=", GO_KIND | 7'd49,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd16: n = mk(6'd48, "<", 7'd27, "=", GO_KIND | 7'd47,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd17: n = mk(6'd46, "=", GO_KIND | 7'd45, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd18: n = mk(6'd58, "=", GO_KIND | 7'd51, ">", 7'd29,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd19: n = mk(6'd57, "=", GO_KIND | 7'd52, ">", 7'd30,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd20: n = mk(6'd56, ">", 7'd31, "=", GO_KIND | 7'd55,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            5'd21: n = mk(6'd54, "=", GO_KIND | 7'd53, CH_NONE, GO_NONE,
                          CH_NONE, GO_NONE, CH_NONE, GO_NONE);
            default: n = mk(6'd13, "=", GO_KIND | 7'd12, CH_NONE, GO_NONE,
                            CH_NONE, GO_NONE, CH_NONE, GO_NONE);
        endcase
        return n;
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] c);
        return c == 21'h20 || c == 21'h09 || c == 21'h0B || c == 21'h0D ||
               c == 21'h85 || c == 21'h200E || c == 21'h200F ||
               c == 21'h2028 || c == 21'h2029;
    endfunction

    function automatic logic is_digit(input logic [CP_W-1:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic is_alpha(input logic [CP_W-1:0] c);
        return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A);
    endfunction

    function automatic logic is_hex(input logic [CP_W-1:0] c);
        return is_digit(c) || (c >= 21'h61 && c <= 21'h66) ||
               (c >= 21'h41 && c <= 21'h46);
    endfunction

    // Bit 6 flags a single-character token; bits 5:0 give its kind.
    function automatic logic [6:0] single_kind(input logic [CP_W-1:0] c);
        logic [6:0] k;
        case (c)
            21'h28:  k = {1'b1, 6'd0};
            21'h29:  k = {1'b1, 6'd1};
            21'h5B:  k = {1'b1, 6'd2};
            21'h5D:  k = {1'b1, 6'd3};
            21'h7B:  k = {1'b1, 6'd4};
            21'h7D:  k = {1'b1, 6'd5};
            21'h2C:  k = {1'b1, 6'd6};
            21'h3A:  k = {1'b1, 6'd7};
            21'h40:  k = {1'b1, 6'd8};
            21'h0A:  k = {1'b1, 6'd9};
            21'h2E:  k = {1'b1, 6'd10};
            21'h7E:  k = {1'b1, 6'd11};
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    // Entry mode of the operator trie, zero when the character opens no operator.
    function automatic logic [4:0] op_entry(input logic [CP_W-1:0] c);
        logic [4:0] m;
        case (c)
            21'h3D:  m = 5'd10;
            21'h2B:  m = 5'd11;
            21'h2D:  m = 5'd12;
            21'h2A:  m = 5'd13;
            21'h2F:  m = 5'd15;
            21'h25:  m = 5'd16;
            21'h26:  m = 5'd17;
            21'h7C:  m = 5'd18;
            21'h5E:  m = 5'd19;
            21'h21:  m = 5'd20;
            21'h3C:  m = 5'd25;
            21'h3E:  m = 5'd28;
            default: m = 5'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/uts_stream_if.sv -----
// Valid/ready stream interface carrying one payload word per handshake.
`default_nettype none

interface uts_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/uts_scan.sv -----
// UTF-8 decoder and scanner state; produces the tokens caused by one source byte.
`default_nettype none

module uts_scan #(
    parameter int OFFSET_BITS   = uts_pkg::DEF_OFFSET_BITS,
    parameter int POSITION_BITS = uts_pkg::DEF_POSITION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  uts_pkg::src_word_t  word,
    output uts_pkg::tok_group_t group
);
    import uts_pkg::*;

    localparam int O = OFFSET_BITS;
    localparam int P = POSITION_BITS;
    localparam int W = (O > P) ? O : P;
    localparam logic [P-1:0] PMAX = {P{1'b1}};

    localparam logic [4:0] M_IDLE  = 5'd0;
    localparam logic [4:0] M_HASH  = 5'd1;
    localparam logic [4:0] M_LINE  = 5'd2;
    localparam logic [4:0] M_BLOCK = 5'd3;
    localparam logic [4:0] M_BSTAR = 5'd4;
    localparam logic [4:0] M_ZERO  = 5'd5;
    localparam logic [4:0] M_INT   = 5'd6;
    localparam logic [4:0] M_FRAC  = 5'd7;
    localparam logic [4:0] M_IDENT = 5'd8;
    localparam logic [4:0] M_STR   = 5'd9;
    localparam logic [4:0] M_OPBASE = 5'd10;

    typedef struct packed {
        logic [O-1:0] off;
        logic [P-1:0] ln;
        logic [P-1:0] cl;
    } pos_t;

    localparam pos_t POS_RESET = '{off: '0, ln: P'(1), cl: P'(1)};

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic [2:0]      seql_reg, seql_next;
    logic [4:0]      mode_reg, mode_next;
    pos_t            pos_reg, pos_next;
    logic [O-1:0]    ts_reg, ts_next;
    logic [1:0]      rdx_reg, rdx_next;

    function automatic pos_t consume(input pos_t p, input logic [CP_W-1:0] c,
                                     input logic [2:0] sl);
        pos_t q;
        q = p;
        if (c == 21'h0A)
        begin
            if (p.ln != PMAX)
                q.ln = p.ln + 1'b1;
            q.cl = P'(1);
        end
        else if (p.cl != PMAX)
        begin
            q.cl = p.cl + 1'b1;
        end
        q.off = p.off + O'(sl);
        return q;
    endfunction

    function automatic token_t make_res(input logic [5:0] kind, input logic pd,
                                        input pos_t p, input logic [O-1:0] ts,
                                        input logic [1:0] rdx);
        logic [O-1:0] delta;
        logic [O-1:0] start;
        logic [W:0]   a;
        logic [W:0]   b;
        logic [W:0]   d;
        token_t       t;
        delta = p.off - ts;
        start = ts + O'(pd);
        if (delta != '0)
            delta = delta - O'({pd, 1'b0});
        a = (W+1)'(p.cl);
        b = (W+1)'(delta);
        d = (a >= b) ? (a - b) : (b - a);
        t.token_kind    = kind;
        t.start_offset  = OFS_W'(start);
        t.lexeme_length = OFS_W'(delta);
        t.line_number   = POS_W'(p.ln);
        t.column_number = POS_W'(d[P-1:0]);
        t.number_radix  = (kind == K_INT || kind == K_FLOAT) ? rdx : 2'd0;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        logic            ended;
        logic            have;
        logic [CP_W-1:0] c;
        logic [7:0]      b;
        logic [4:0]      md;
        pos_t            p;
        logic [O-1:0]    ts;
        logic [1:0]      rdx;
        logic            done;
        logic            hit;
        logic [6:0]      l;
        logic [6:0]      sk;
        logic [4:0]      oe;
        logic [6:0]      go;
        op_node_t        nd;
        token_t          res [4];
        logic [2:0]      n;
        logic [1:0]      cnt;

        b         = word.source_byte;
        ended     = 1'b0;
        have      = 1'b0;
        c         = '0;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        seql_next = seql_reg;
        md        = mode_reg;
        p         = pos_reg;
        ts        = ts_reg;
        rdx       = rdx_reg;
        done      = 1'b0;
        hit       = 1'b0;
        l         = '0;
        sk        = '0;
        oe        = '0;
        go        = '0;
        nd        = op_node(5'd0);
        n         = 3'd0;
        for (int i = 0; i < 4; i++)
            res[i] = '0;

        // UTF-8 decode.
        if (rem_reg == 2'd0)
        begin
            if (b == 8'h00)
                ended = 1'b1;
            else if (b[7] == 1'b0)
            begin
                c = CP_W'(b);
                seql_next = 3'd1;
                have = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                acc_next = CP_W'(b[4:0]);
                rem_next = 2'd1;
                seql_next = 3'd2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc_next = CP_W'(b[3:0]);
                rem_next = 2'd2;
                seql_next = 3'd3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                acc_next = CP_W'(b[2:0]);
                rem_next = 2'd3;
                seql_next = 3'd4;
            end
            else
                ended = 1'b1;
        end
        else
        begin
            acc_next = {acc_reg[CP_W-7:0], b[5:0]};
            rem_next = rem_reg - 2'd1;
            if (rem_reg == 2'd1)
            begin
                c = acc_next;
                have = 1'b1;
            end
        end

        if (have && c == '0)
            ended = 1'b1;

        if (have && c != '0)
        begin
            // A comment opener decides between line and block comment.
            if (md == M_HASH)
            begin
                if (c == 21'h2A)
                begin
                    p = consume(p, c, seql_next);
                    md = M_BLOCK;
                    done = 1'b1;
                end
                else
                    md = M_LINE;
            end

            if (!done && md == M_ZERO)
            begin
                md = M_INT;
                l = c[6:0] | 7'h20;
                if (l == 7'h62 || l == 7'h63 || l == 7'h78)
                begin
                    rdx = (l == 7'h62) ? 2'd1 : (l == 7'h63) ? 2'd2 : 2'd3;
                    p = consume(p, c, seql_next);
                    done = 1'b1;
                end
            end

            if (!done)
            begin
                case (md)
                    M_IDLE: ;
                    M_LINE:
                    begin
                        if (c == 21'h0A)
                            md = M_IDLE;
                        else
                        begin
                            p = consume(p, c, seql_next);
                            done = 1'b1;
                        end
                    end
                    M_BLOCK:
                    begin
                        p = consume(p, c, seql_next);
                        if (c == 21'h2A)
                            md = M_BSTAR;
                        done = 1'b1;
                    end
                    M_BSTAR:
                    begin
                        p = consume(p, c, seql_next);
                        if (c == 21'h23)
                            md = M_IDLE;
                        else if (c != 21'h2A)
                            md = M_BLOCK;
                        done = 1'b1;
                    end
                    M_INT, M_FRAC:
                    begin
                        if (is_hex(c) || c == 21'h5F)
                        begin
                            p = consume(p, c, seql_next);
                            done = 1'b1;
                        end
                        else if (md == M_INT && c == 21'h2E)
                        begin
                            p = consume(p, c, seql_next);
                            md = M_FRAC;
                            done = 1'b1;
                        end
                        else
                        begin
                            res[n[1:0]] = make_res((md == M_INT) ? K_INT : K_FLOAT,
                                                   1'b0, p, ts, rdx);
                            n = n + 3'd1;
                            md = M_IDLE;
                        end
                    end
                    M_IDENT:
                    begin
                        if (c == 21'h5F || is_alpha(c) || is_digit(c))
                        begin
                            p = consume(p, c, seql_next);
                            done = 1'b1;
                        end
                        else
                        begin
                            res[n[1:0]] = make_res(K_IDENT, 1'b0, p, ts, rdx);
                            n = n + 3'd1;
                            md = M_IDLE;
                        end
                    end
                    M_STR:
                    begin
                        p = consume(p, c, seql_next);
                        if (c == 21'h22)
                        begin
                            res[n[1:0]] = make_res(K_STRING, 1'b1, p, ts, rdx);
                            n = n + 3'd1;
                            md = M_IDLE;
                        end
                        done = 1'b1;
                    end
                    default:
                    begin
                        // Operator trie: first matching edge wins.
                        nd = op_node(md - M_OPBASE);
                        for (int i = 0; i < 4; i++)
                        begin
                            if (!hit && nd.ch[i] != CH_NONE && CP_W'(nd.ch[i]) == c)
                            begin
                                hit = 1'b1;
                                go = nd.go[i];
                            end
                        end
                        if (hit)
                        begin
                            p = consume(p, c, seql_next);
                            if ((go & GO_KIND) != GO_NONE)
                            begin
                                res[n[1:0]] = make_res(go[5:0], 1'b0, p, ts, rdx);
                                n = n + 3'd1;
                                md = M_IDLE;
                            end
                            else
                                md = go[4:0];
                            done = 1'b1;
                        end
                        else
                        begin
                            res[n[1:0]] = make_res(nd.dflt, 1'b0, p, ts, rdx);
                            n = n + 3'd1;
                            md = M_IDLE;
                        end
                    end
                endcase
            end

            if (!done && md == M_IDLE)
            begin
                if (is_space(c))
                    p = consume(p, c, seql_next);
                else if (c == 21'h23)
                begin
                    p = consume(p, c, seql_next);
                    md = M_HASH;
                end
                else
                begin
                    ts = p.off;
                    if (is_digit(c))
                    begin
                        rdx = 2'd0;
                        md = (c == 21'h30) ? M_ZERO : M_INT;
                        p = consume(p, c, seql_next);
                    end
                    else
                    begin
                        p = consume(p, c, seql_next);
                        sk = single_kind(c);
                        oe = op_entry(c);
                        if (sk[6])
                        begin
                            res[n[1:0]] = make_res(sk[5:0], 1'b0, p, ts, rdx);
                            n = n + 3'd1;
                        end
                        else if (oe != 5'd0)
                            md = oe;
                        else if (c == 21'h22)
                            md = M_STR;
                        else if (c == 21'h5F || is_alpha(c))
                            md = M_IDENT;
                        else
                        begin
                            res[n[1:0]] = make_res(K_ERR, 1'b0, p, ts, rdx);
                            n = n + 3'd1;
                        end
                    end
                end
            end
        end

        if (word.end_of_source)
            ended = 1'b1;

        // End of source closes the pending token and appends EOF.
        if (ended)
        begin
            case (md)
                M_IDLE, M_HASH, M_LINE, M_BLOCK, M_BSTAR: ;
                M_ZERO, M_INT:
                begin
                    res[n[1:0]] = make_res(K_INT, 1'b0, p, ts, rdx);
                    n = n + 3'd1;
                end
                M_FRAC:
                begin
                    res[n[1:0]] = make_res(K_FLOAT, 1'b0, p, ts, rdx);
                    n = n + 3'd1;
                end
                M_IDENT:
                begin
                    res[n[1:0]] = make_res(K_IDENT, 1'b0, p, ts, rdx);
                    n = n + 3'd1;
                end
                M_STR:
                begin
                    res[n[1:0]] = make_res(K_ERR, 1'b0, p, ts, rdx);
                    n = n + 3'd1;
                end
                default:
                begin
                    nd = op_node(md - M_OPBASE);
                    res[n[1:0]] = make_res(nd.dflt, 1'b0, p, ts, rdx);
                    n = n + 3'd1;
                end
            endcase
            if (n < 3'd3)
            begin
                res[n[1:0]] = '0;
                res[n[1:0]].token_kind   = K_EOF;
                res[n[1:0]].start_offset = OFS_W'(p.off);
                res[n[1:0]].line_number  = POS_W'(p.ln);
                n = n + 3'd1;
            end
        end

        cnt = (n > 3'd3) ? 2'd3 : n[1:0];
        if (cnt != 2'd0)
            res[cnt - 2'd1].last_of_run = 1'b1;
        group.count = cnt;
        group.item  = {res[2], res[1], res[0]};

        if (ended)
        begin
            acc_next  = '0;
            rem_next  = 2'd0;
            seql_next = 3'd1;
            mode_next = M_IDLE;
            pos_next  = POS_RESET;
            ts_next   = '0;
            rdx_next  = 2'd0;
        end
        else
        begin
            mode_next = md;
            pos_next  = p;
            ts_next   = ts;
            rdx_next  = rdx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= 2'd0;
            seql_reg <= 3'd1;
            mode_reg <= M_IDLE;
            pos_reg  <= POS_RESET;
            ts_reg   <= '0;
            rdx_reg  <= 2'd0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            seql_reg <= seql_next;
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            rdx_reg  <= rdx_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8_source_tokenizer.sv -----
// Top level of the UTF-8 source tokenizer: scanner plus token output buffer.
//
// Usage: the text channel takes one source byte per word, with end_of_source
// marking the final byte. The tokens channel delivers one token per word;
// last_of_run marks the final token caused by a given byte.
// Each accepted byte is decoded and scanned in the cycle it is taken, and the
// zero to three tokens it causes appear on the tokens channel from the next
// cycle on, one per cycle while the receiver is ready. Bytes that cause no
// token or one token are taken one per cycle with the receiver ready; after a
// byte causing more tokens, text.ready stays low while the output buffer
// drains, until the cycle in which its last token is taken.
// The buffer takes a new byte in the same cycle as its last token is taken,
// so a one-token stream runs at full rate with the receiver ready.
// When the receiver stalls, the buffered tokens hold and text.ready stays
// low until the last one is taken.
// Reset empties the buffer and returns the scanner to the start of a source:
// offset 0, line 1, column 1. The scanner returns to that start after an EOF token.
`default_nettype none

module utf8_source_tokenizer #(
    parameter int OFFSET_BITS   = uts_pkg::DEF_OFFSET_BITS,
    parameter int POSITION_BITS = uts_pkg::DEF_POSITION_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    uts_stream_if.sink   text,
    uts_stream_if.source tokens
);
    import uts_pkg::*;

    tok_group_t   group;
    logic         accept;
    logic         take;
    logic         last_take;
    token_t [2:0] buf_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   idx_reg;

    assign take      = tokens.valid && tokens.ready;
    assign last_take = take && (idx_reg == cnt_reg - 2'd1);
    assign text.ready = (cnt_reg == 2'd0) || last_take;
    assign accept    = text.valid && text.ready;

    assign tokens.valid   = (cnt_reg != 2'd0);
    assign tokens.payload = buf_reg[idx_reg];

    uts_scan #(
        .OFFSET_BITS   (OFFSET_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (text.payload),
        .group  (group)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= group.count;
            idx_reg <= 2'd0;
        end
        else if (last_take)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_reg <= group.item;
    end

endmodule

`default_nettype wire

// ----- rtl/uts_checker.sv -----
// Port-level assertions for the UTF-8 source tokenizer, bound to the top level.
`default_nettype none

module uts_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            tok_valid,
    input logic            tok_ready,
    input uts_pkg::token_t tok_data
);
    import uts_pkg::*;

    // A token waiting on the receiver does not vanish.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid)
        else $error("token dropped while stalled");

    // EOF closes the run of tokens of its byte.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind == K_EOF |-> tok_data.last_of_run)
        else $error("EOF token not last of run");

    // EOF carries no lexeme and no column.
    a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind == K_EOF |->
            tok_data.lexeme_length == '0 && tok_data.column_number == '0)
        else $error("EOF token with nonzero length or column");

    // Only numbers carry a radix.
    a_radix: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind != K_INT && tok_data.token_kind != K_FLOAT
            |-> tok_data.number_radix == 2'd0)
        else $error("radix on a non-number token");

endmodule

bind utf8_source_tokenizer uts_checker u_uts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tokens.valid),
    .tok_ready (tokens.ready),
    .tok_data  (tokens.payload)
);

`default_nettype wire
